// ----- hw/rtl/tkbv_pkg.sv -----
// tkbv_pkg: shared types and constants for the top-k best value keeper
// no dependencies; used by tkbv_ram and top_k_best_value_keeper
package tkbv_pkg;

    localparam int unsigned MAX_ENTRIES = 64;

    localparam int unsigned ID_W     = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned COUNT_W  = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic KIND_INSERT_ACK = 1'b0;
    localparam logic KIND_READ_DATA  = 1'b1;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic signed [VALUE_W-1:0]  value;
        logic [HANDLE_W-1:0]        handle;
    } entry_t;

endpackage

// ----- hw/rtl/top_k_best_value_keeper.sv -----
// top_k_best_value_keeper: keeps the best-scoring entries, replacing the lowest when full
// depends on tkbv_pkg and tkbv_ram
// accept to result valid: read via ST_RD_WAIT, ST_FINISH; insert while not full via
//   ST_FINISH; full-store insert: ST_SCAN (one store read per slot), ST_DECIDE, ST_FINISH
// throughput: one item at a time, next item taken when the previous result is registered
// reset: fill count 0, capacity 64; store contents undefined until written, no clearing pass
module top_k_best_value_keeper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tkbv_pkg::COUNT_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [tkbv_pkg::ID_W-1:0]         move_id,
    input  logic signed [tkbv_pkg::VALUE_W-1:0] move_score,
    input  logic [tkbv_pkg::HANDLE_W-1:0]     payload_handle,
    input  logic [tkbv_pkg::INDEX_W-1:0]      read_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic                              accepted,
    output logic [tkbv_pkg::INDEX_W-1:0]      slot,
    output logic [tkbv_pkg::ID_W-1:0]         out_move_id,
    output logic signed [tkbv_pkg::VALUE_W-1:0] out_value,
    output logic [tkbv_pkg::HANDLE_W-1:0]     out_handle,
    output logic [tkbv_pkg::COUNT_W-1:0]      fill_count
);
    import tkbv_pkg::*;

    localparam int unsigned ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [COUNT_W-1:0]          capacity_reg;
    logic [COUNT_W-1:0]          count_reg, count_next;
    entry_t                      cand_reg, cand_next;
    logic [COUNT_W-1:0]          issue_reg, issue_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [COUNT_W-1:0]          chk_idx_reg, chk_idx_next;
    logic signed [VALUE_W-1:0]   least_reg, least_next;
    logic [COUNT_W-1:0]          best_reg, best_next;
    logic                        res_kind_reg, res_kind_next;
    logic                        res_ok_reg, res_ok_next;
    logic [INDEX_W-1:0]          res_slot_reg, res_slot_next;
    entry_t                      res_entry_reg, res_entry_next;
    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic                        out_ok_reg;
    logic [INDEX_W-1:0]          out_slot_reg;
    entry_t                      out_entry_reg;
    logic [COUNT_W-1:0]          out_fill_reg;

    logic [COUNT_W-1:0]          cap_eff;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    entry_t                      mem_wdata;
    logic [ADDR_W-1:0]           mem_raddr;
    entry_t                      mem_rdata;
    logic                        out_free;

    tkbv_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = COUNT_W'(1);
        end
        else if (capacity_reg > MAX_CNT)
        begin
            cap_eff = MAX_CNT;
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cand_next      = cand_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        least_next     = least_reg;
        best_next      = best_reg;
        res_kind_next  = res_kind_reg;
        res_ok_next    = res_ok_reg;
        res_slot_next  = res_slot_reg;
        res_entry_next = res_entry_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = cand_reg;
        mem_raddr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cand_next.id     = move_id;
                    cand_next.value  = move_score;
                    cand_next.handle = payload_handle;
                    res_kind_next    = cmd;
                    res_entry_next   = '0;
                    if (cmd == CMD_READ)
                    begin
                        mem_raddr     = read_index[ADDR_W-1:0];
                        res_slot_next = read_index;
                        res_ok_next   = (COUNT_W'(read_index) < count_reg) &&
                                        (COUNT_W'(read_index) < MAX_CNT);
                        state_next    = ST_RD_WAIT;
                    end
                    else if (count_reg < cap_eff)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = count_reg[ADDR_W-1:0];
                        mem_wdata.id     = move_id;
                        mem_wdata.value  = move_score;
                        mem_wdata.handle = payload_handle;
                        res_ok_next      = 1'b1;
                        res_slot_next    = INDEX_W'(count_reg);
                        count_next       = count_reg + COUNT_W'(1);
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        mem_raddr      = '0;
                        issue_next     = COUNT_W'(1);
                        chk_valid_next = 1'b1;
                        chk_idx_next   = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_RD_WAIT:
            begin
                if (res_ok_reg)
                begin
                    res_entry_next = mem_rdata;
                end
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                // issue the next slot read while checking the one that returned
                if (issue_reg < cap_eff)
                begin
                    mem_raddr      = issue_reg[ADDR_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg;
                    issue_next     = issue_reg + COUNT_W'(1);
                end
                if (chk_valid_reg)
                begin
                    if ((chk_idx_reg == '0) || (mem_rdata.value < least_reg))
                    begin
                        least_next = mem_rdata.value;
                        best_next  = chk_idx_reg;
                    end
                    if (chk_idx_reg == cap_eff - COUNT_W'(1))
                    begin
                        chk_valid_next = 1'b0;
                        state_next     = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (least_reg < cand_reg.value)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = best_reg[ADDR_W-1:0];
                    res_ok_next   = 1'b1;
                    res_slot_next = INDEX_W'(best_reg);
                end
                else
                begin
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAPACITY_RESET;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        issue_reg     <= issue_next;
        chk_idx_reg   <= chk_idx_next;
        least_reg     <= least_next;
        best_reg      <= best_next;
        res_kind_reg  <= res_kind_next;
        res_ok_reg    <= res_ok_next;
        res_slot_reg  <= res_slot_next;
        res_entry_reg <= res_entry_next;
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_kind_reg  <= res_kind_reg;
            out_ok_reg    <= res_ok_reg;
            out_slot_reg  <= res_slot_reg;
            out_entry_reg <= res_entry_reg;
            out_fill_reg  <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign accepted    = out_ok_reg;
    assign slot        = out_slot_reg;
    assign out_move_id = out_entry_reg.id;
    assign out_value   = out_entry_reg.value;
    assign out_handle  = out_entry_reg.handle;
    assign fill_count  = out_fill_reg;

endmodule

// ----- hw/rtl/tkbv_ram.sv -----
// tkbv_ram: entry store, one write port and one registered read port
// depends on tkbv_pkg for entry_t
module tkbv_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  tkbv_pkg::entry_t     wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output tkbv_pkg::entry_t     rdata
);
    import tkbv_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for top_k_best_value_keeper, with a queue-fed driver,
// a monitor and a built-in predictor of the kept entries and the capacity register
// depends on tkbv_pkg and top_k_best_value_keeper
module testbench;

    import tkbv_pkg::*;

    localparam int unsigned SLOTS   = MAX_ENTRIES;
    localparam int unsigned SETTLE  = 6;
    localparam int unsigned TAIL    = 80;
    localparam int unsigned PHASE_N = 185;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CAP, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t                 kind;
        logic [COUNT_W-1:0]         cap;
        logic                       cmd;
        logic [ID_W-1:0]            id;
        logic signed [VALUE_W-1:0]  value;
        logic [HANDLE_W-1:0]        handle;
        logic [INDEX_W-1:0]         idx;
    } step_t;

    typedef struct packed {
        logic                   kind;
        logic                   ok;
        logic [INDEX_W-1:0]     slot;
        logic [ID_W-1:0]        id;
        logic [VALUE_W-1:0]     value;
        logic [HANDLE_W-1:0]    handle;
        logic [COUNT_W-1:0]     fill;
    } result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [COUNT_W-1:0]         cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       cmd = CMD_INSERT;
    logic [ID_W-1:0]            move_id = '0;
    logic signed [VALUE_W-1:0]  move_score = '0;
    logic [HANDLE_W-1:0]        payload_handle = '0;
    logic [INDEX_W-1:0]         read_index = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       result_kind;
    logic                       accepted;
    logic [INDEX_W-1:0]         slot;
    logic [ID_W-1:0]            out_move_id;
    logic signed [VALUE_W-1:0]  out_value;
    logic [HANDLE_W-1:0]        out_handle;
    logic [COUNT_W-1:0]         fill_count;

    top_k_best_value_keeper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .move_id       (move_id),
        .move_score    (move_score),
        .payload_handle(payload_handle),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .accepted      (accepted),
        .slot          (slot),
        .out_move_id   (out_move_id),
        .out_value     (out_value),
        .out_handle    (out_handle),
        .fill_count    (fill_count)
    );

    // stimulus and expectations
    step_t      pending_steps[$];
    result_t    ranked_q[$];
    step_t      cur_item;
    int         sent = 0;
    int         got = 0;
    int         errors = 0;
    int         cap_writes = 0;
    int         quiet = 0;

    // predictor state
    logic [COUNT_W-1:0]         kept_count = '0;
    logic [COUNT_W-1:0]         cap_reg = CAPACITY_RESET;
    logic [ID_W-1:0]            kept_id[SLOTS];
    logic signed [VALUE_W-1:0]  kept_value[SLOTS];
    logic [HANDLE_W-1:0]        kept_handle[SLOTS];

    // generator-side view of the fill count, used to aim reads at stored slots
    int unsigned                gen_count = 0;
    logic [COUNT_W-1:0]         gen_cap = CAPACITY_RESET;
    logic [VALUE_W-1:0]         ramp_value = 32'h8000_0000;

    function automatic int unsigned usable_slots(input logic [COUNT_W-1:0] c);
        if (c == '0)
            return 1;
        if (32'(c) > SLOTS)
            return SLOTS;
        return 32'(c);
    endfunction

    task automatic rank_item(input step_t it, output result_t r);
        int unsigned lim;
        int unsigned low_slot;
        logic signed [VALUE_W-1:0] low_val;
        logic signed [VALUE_W-1:0] cand;
        r = '0;
        cand = it.value;
        r.kind = (it.cmd == CMD_INSERT) ? KIND_INSERT_ACK : KIND_READ_DATA;
        if (it.cmd == CMD_INSERT)
        begin
            lim = usable_slots(cap_reg);
            if (32'(kept_count) < lim)
            begin
                kept_id[kept_count[INDEX_W-1:0]] = it.id;
                kept_value[kept_count[INDEX_W-1:0]] = cand;
                kept_handle[kept_count[INDEX_W-1:0]] = it.handle;
                r.ok = 1'b1;
                r.slot = kept_count[INDEX_W-1:0];
                kept_count = kept_count + COUNT_W'(1);
            end
            else
            begin
                low_slot = 0;
                low_val = kept_value[0];
                for (int i = 1; i < lim; i++)
                begin
                    if (kept_value[i] < low_val)
                    begin
                        low_val = kept_value[i];
                        low_slot = i;
                    end
                end
                if (low_val < cand)
                begin
                    kept_id[low_slot[INDEX_W-1:0]] = it.id;
                    kept_value[low_slot[INDEX_W-1:0]] = cand;
                    kept_handle[low_slot[INDEX_W-1:0]] = it.handle;
                    r.ok = 1'b1;
                    r.slot = low_slot[INDEX_W-1:0];
                end
            end
        end
        else
        begin
            r.slot = it.idx;
            if (COUNT_W'(it.idx) < kept_count)
            begin
                r.ok = 1'b1;
                r.id = kept_id[it.idx];
                r.value = kept_value[it.idx];
                r.handle = kept_handle[it.idx];
            end
        end
        r.fill = kept_count;
    endtask

    task automatic push_insert(input logic [ID_W-1:0] id, input logic [VALUE_W-1:0] value,
                               input logic [HANDLE_W-1:0] handle);
        step_t s;
        s.kind = STEP_ITEM;
        s.cap = '0;
        s.cmd = CMD_INSERT;
        s.id = id;
        s.value = value;
        s.handle = handle;
        s.idx = INDEX_W'($urandom_range(0, SLOTS - 1));
        pending_steps.push_back(s);
        if (gen_count < usable_slots(gen_cap))
            gen_count++;
    endtask

    task automatic push_read(input logic [INDEX_W-1:0] idx);
        step_t s;
        s.kind = STEP_ITEM;
        s.cap = '0;
        s.cmd = CMD_READ;
        s.id = ID_W'($urandom_range(0, 65535));
        s.value = $urandom;
        s.handle = HANDLE_W'($urandom_range(0, 65535));
        s.idx = idx;
        pending_steps.push_back(s);
    endtask

    task automatic push_ctrl(input step_kind_t kind, input logic [COUNT_W-1:0] cap);
        step_t s;
        s = cur_item;
        s.kind = kind;
        s.cap = cap;
        pending_steps.push_back(s);
        if (kind == STEP_CAP)
            gen_cap = cap;
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] cap, input int n);
        logic [VALUE_W-1:0] v;
        int unsigned hi;
        push_ctrl(STEP_CAP, cap);
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2)
                push_ctrl(STEP_DRAIN, '0);
            if ($urandom_range(0, 99) < 65)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v = $urandom;
                    4, 5, 6:    v = ($urandom_range(0, 6) - 3) * 65536;
                    7:
                    begin
                        ramp_value = ramp_value + $urandom_range(1, 4096) * 64;
                        v = ramp_value;
                    end
                    8:          v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default:    v = 32'h7FFF_FF00 + $urandom_range(0, 255);
                endcase
                push_insert(ID_W'($urandom_range(0, 65535)), v,
                            HANDLE_W'($urandom_range(0, 65535)));
            end
            else
            begin
                hi = (gen_count == 0) ? 0 : gen_count - 1;
                if ($urandom_range(0, 99) < 60)
                    push_read(INDEX_W'($urandom_range(0, hi)));
                else
                    push_read(INDEX_W'($urandom_range(0, SLOTS - 1)));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] seen_v);
        if (want_v !== seen_v)
        begin
            $error("%s: expected %0h, actual %0h", name, want_v, seen_v);
            errors++;
        end
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        step_t head;
        result_t want;
        logic valid_nx;
        logic we_nx;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            valid_nx = in_valid;
            we_nx = 1'b0;
            if (in_valid && in_ready)
            begin
                rank_item(cur_item, want);
                ranked_q.push_back(want);
                sent <= sent + 1;
                valid_nx = 1'b0;
            end
            if (in_valid || sent != got)
                quiet = 0;
            else if (quiet < 15)
                quiet++;
            if (!valid_nx && pending_steps.size() > 0)
            begin
                head = pending_steps[0];
                if (head.kind == STEP_ITEM)
                begin
                    if ((sent >= 700 && sent < 1000) || $urandom_range(0, 99) >= 25)
                    begin
                        cur_item = head;
                        cmd <= head.cmd;
                        move_id <= head.id;
                        move_score <= head.value;
                        payload_handle <= head.handle;
                        read_index <= head.idx;
                        valid_nx = 1'b1;
                        void'(pending_steps.pop_front());
                    end
                end
                else if (quiet >= SETTLE)
                begin
                    if (head.kind == STEP_CAP)
                    begin
                        we_nx = 1'b1;
                        cfg_data <= head.cap;
                        cap_reg = head.cap;
                        cap_writes++;
                    end
                    void'(pending_steps.pop_front());
                    quiet = 0;
                end
            end
            in_valid <= valid_nx;
            cfg_we <= we_nx;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (ranked_q.size() == 0)
                begin
                    $error("unexpected transfer: kind %0b slot %0d", result_kind, slot);
                    errors++;
                end
                else
                begin
                    want = ranked_q.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("accepted", 32'(want.ok), 32'(accepted));
                    check_field("slot", 32'(want.slot), 32'(slot));
                    check_field("out_move_id", 32'(want.id), 32'(out_move_id));
                    check_field("out_value", want.value, out_value);
                    check_field("out_handle", 32'(want.handle), 32'(out_handle));
                    check_field("fill_count", 32'(want.fill), 32'(fill_count));
                end
                got <= got + 1;
            end
            out_ready <= (got >= 650 && got < 1050) || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        // directed: reset capacity, empty reads, value and field extremes
        push_read(6'd0);
        push_read(6'd63);
        push_insert(16'h0000, 32'h8000_0000, 16'h0000);
        push_insert(16'hFFFF, 32'h7FFF_FFFF, 16'hFFFF);
        push_insert(16'h1234, 32'hFFFF_FFFF, 16'hABCD);
        push_read(6'd0);
        push_read(6'd1);
        push_read(6'd2);
        push_read(6'd3);
        // zero capacity acts as one; equal value is discarded
        push_ctrl(STEP_CAP, 7'd0);
        push_insert(16'h0F0F, 32'h8000_0000, 16'hF0F0);
        push_insert(16'h5555, 32'h0000_0000, 16'hAAAA);
        push_read(6'd0);
        // capacity below fill: only the low slots are replaceable
        push_ctrl(STEP_CAP, 7'd2);
        push_insert(16'h0001, 32'hFFFF_FFFF, 16'h0001);
        push_insert(16'h0002, 32'h0000_0000, 16'h0002);
        push_insert(16'h0003, 32'h0005_0000, 16'h0003);
        push_read(6'd2);
        // capacity above the store size acts as the store size
        push_ctrl(STEP_CAP, 7'd127);
        push_insert(16'hAAAA, 32'h0001_8000, 16'h5555);
        push_read(6'd3);
        push_read(6'd63);

        run_phase(7'd10, PHASE_N);
        run_phase(7'd20, PHASE_N);
        run_phase(7'd1, PHASE_N);
        run_phase(7'd40, PHASE_N);
        run_phase(7'd127, PHASE_N);
        run_phase(7'd64, PHASE_N);
        run_phase(7'd0, PHASE_N);
        run_phase(COUNT_W'($urandom_range(2, 63)), PHASE_N);
        run_phase(7'd33, PHASE_N);
        run_phase(7'd5, PHASE_N);

        @(posedge rst_n);
        while (pending_steps.size() != 0 || in_valid || sent != got)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);
        if (ranked_q.size() != 0)
        begin
            $error("%0d expected results never arrived", ranked_q.size());
            errors++;
        end
        $display("covered %0d items and %0d checked transfers over %0d capacity writes",
                 sent, got, cap_writes);
        $display("final fill count %0d, capacity register %0d", kept_count, cap_reg);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", ranked_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tkbv_pkg.sv
hw/rtl/tkbv_ram.sv
hw/rtl/top_k_best_value_keeper.sv
tb/testbench.sv
